/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the digest block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types and constants of the digest block.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_valid;
        logic       end_of_message;
    } item_t;

    typedef logic [31:0] word_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

/* src/sha256_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input transactions into a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_front #(
    parameter int DEPTH = sha256_pkg::QueueDepth
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire                  in_valid,
    input  wire [7:0]            in_byte,
    input  wire                  in_last,
    output logic                 q_valid,
    output sha256_pkg::item_t    q_item,
    input  wire                  q_pop
);
    import sha256_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;

    assign s_tready = (count_reg != CW'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{message_byte: in_byte, byte_valid: in_valid,
                                 end_of_message: in_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(q_pop && q_valid);
        end
    end
endmodule
`default_nettype wire

/* src/sha256_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 back end
// Packs bytes, pads, runs the rounds and sends out the digest words.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  q_valid,
    input  sha256_pkg::item_t    q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [31:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    word_t       chain_reg [8];
    word_t       var_reg [8];
    word_t       blk_reg [16];
    logic [63:0] bits_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        last_pend_reg, mark_reg, len_phase_reg;

    logic        put_en;
    logic [7:0]  put_val;
    word_t       s0, s1, w_new, big0, big1, ch, maj, t1, t2;

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == 3'd7);
    assign q_pop    = (state_reg == ST_IDLE);

    always_comb
    begin
        put_en  = 1'b0;
        put_val = q_item.message_byte;
        if (state_reg == ST_IDLE)
        begin
            put_en = q_valid && q_item.byte_valid;
        end
        else if (state_reg == ST_PAD)
        begin
            put_en = 1'b1;
            if (!mark_reg)
            begin
                put_val = PAD_MARK;
            end
            else if (len_phase_reg || pos_reg == LEN_POS)
            begin
                put_val = bits_reg[63 - 8 * pos_reg[2:0] -: 8];
            end
            else
            begin
                put_val = 8'h00;
            end
        end
    end

    always_comb
    begin
        s0    = rotr(blk_reg[1], 7) ^ rotr(blk_reg[1], 18) ^ (blk_reg[1] >> 3);
        s1    = rotr(blk_reg[14], 17) ^ rotr(blk_reg[14], 19) ^ (blk_reg[14] >> 10);
        w_new = s1 + blk_reg[9] + s0 + blk_reg[0];
        big1  = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
        ch    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1    = var_reg[7] + big1 + ch + RK[rnd_reg] + blk_reg[0];
        big0  = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
        maj   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]);
        t2    = big0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (put_en && pos_reg == 6'd63)
                    begin
                        state_next = ST_RND;
                    end
                    else if (q_item.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pos_reg == 6'd63)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (last_pend_reg && len_phase_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (last_pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (m_tready && idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            blk_reg[pos_reg[5:2]][8 * (3 - pos_reg[1:0]) +: 8] <= put_val;
        end
        else if (state_reg == ST_RND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                blk_reg[i] <= blk_reg[i + 1];
            end
            blk_reg[15] <= w_new;
        end
        if (state_next == ST_RND && state_reg != ST_RND)
        begin
            var_reg <= chain_reg;
        end
        else if (state_reg == ST_RND)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg     <= IV;
            bits_reg      <= '0;
            pos_reg       <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            last_pend_reg <= 1'b0;
            mark_reg      <= 1'b0;
            len_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (put_en)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (state_reg == ST_IDLE && put_en)
            begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (state_reg == ST_IDLE && q_valid)
            begin
                last_pend_reg <= q_item.end_of_message;
            end
            if (state_reg == ST_PAD)
            begin
                mark_reg <= 1'b1;
                if (mark_reg && pos_reg == LEN_POS)
                begin
                    len_phase_reg <= 1'b1;
                end
            end
            if (state_reg == ST_RND)
            begin
                rnd_reg <= rnd_reg + 1'b1;
            end
            if (state_reg == ST_FIN)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            if (state_reg == ST_OUT && m_tready)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == 3'd7)
                begin
                    chain_reg     <= IV;
                    bits_reg      <= '0;
                    pos_reg       <= '0;
                    last_pend_reg <= 1'b0;
                    mark_reg      <= 1'b0;
                    len_phase_reg <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* src/sha256_message_digest.sv */
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Hashes a byte stream; sends the eight digest words at the end of a message.
// ----------------------------------------------------------------------------
// Input: one transaction per item on s_*. tdata carries the message byte,
// tuser the byte-valid flag, tlast ends the message (tuser low with tlast
// high hashes the empty message). Output: eight transactions on m_* per
// message, tdata the digest word, tuser its index 0..7, tlast on word 7.
// A two-entry queue holds input transactions while the back end works.
// The back end takes one byte per cycle while idle; each filled 64-byte
// block then takes 64 rounds on one round unit and a chaining add. At the end
// of a message it pads one byte per cycle (up to 72 bytes, one or two
// blocks), then presents the digest words, one per cycle while m_tready
// is high. When the receiver stalls, the current word holds and the queue
// fills, after which s_tready drops. Reset loads the initial hash values,
// empties the queue and clears the length; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sha256_message_digest #(
    parameter int QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] message_byte
    input  wire         s_tuser,   // [0] byte_valid
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);
    import sha256_pkg::*;

    logic  q_valid, q_pop;
    item_t q_item;

    sha256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_valid(s_tuser), .in_byte(s_tdata), .in_last(s_tlast),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    sha256_core u_core (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    `ASSERT_NEXT(a_last_ends, clk, rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)
    `ASSERT_IMPLIES(a_last_idx, clk, rst_n, m_tvalid, m_tlast == (m_tuser == 3'd7))
    `ASSERT_NEXT(a_word_step, clk, rst_n, m_tvalid && m_tready && !m_tlast,
        m_tvalid && m_tuser == $past(m_tuser) + 3'd1)
endmodule
`default_nettype wire
